### rtl/iq_amplitude_phase_difference_unit_defines.svh
// Assertion helpers for the amplitude / phase difference block.
`ifndef IQ_AMPLITUDE_PHASE_DIFFERENCE_UNIT_DEFINES_SVH
`define IQ_AMPLITUDE_PHASE_DIFFERENCE_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define IQAPD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define IQAPD_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/iqapd_pkg.sv
package iqapd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int OFFSET_W  = 15;
  localparam int LOG_STEPS = 16;
  localparam int ATAN_W    = 22;

  localparam logic [14:0] OFFSET_RESET = 15'd20480;
  // round(10*log10(2) * 2^24)
  localparam logic [31:0] LOG_K        = 32'd50504453;
  localparam int          HALF_TURN    = 23040;
  localparam int          FULL_TURN    = 46080;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_phase;
    logic signed [SAMPLE_W-1:0] quadrature;
    logic                       start_of_record;
  } in_t;

  typedef struct packed {
    logic signed [15:0] amplitude_db;
    logic signed [15:0] phase_step;
  } out_t;

  // atan(2^-k) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] k);
    logic [ATAN_W-1:0] v;
    unique case (k)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/iq_amplitude_phase_difference_unit.sv
// I/Q amplitude and phase difference unit.
// Input channel (in_valid / in_stall / in_data): one complex sample per
// request, with a start_of_record flag. Output channel (out_valid /
// out_stall / out_data): one result per request, amplitude in 1/256 dB
// less the programmed offset, and the phase step from the previous sample
// in 1/128 degree, wrapped once into -180..180.
// cfg_write_enable / cfg_write_data program the amplitude offset; write it
// only while the block is idle.
// From acceptance to out_valid a sample goes through these steps in
// order: two squaring passes, one normalize step, one loop step per log
// bit / CORDIC stage (both run side by side), one scaling step and one
// result step. A single shared multiplier does the squares, the log mantissa
// squaring and the dB scaling; the loop length sets the rate. in_stall
// stays high from acceptance until the result is loaded into the output
// register, so a new request is taken only after the last result is loaded.
// If the receiver stalls, the result holds in the output register and the
// block waits in its result state until the register frees.
// Synchronous reset clears the sequencer and out_valid, sets the offset to
// 80 dB and the previous phase to zero.
`include "iq_amplitude_phase_difference_unit_defines.svh"

module iq_amplitude_phase_difference_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  iqapd_pkg::in_t                     in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output iqapd_pkg::out_t                    out_data,
  input  logic                               cfg_write_enable,
  input  logic [iqapd_pkg::OFFSET_W-1:0]     cfg_write_data
);
  import iqapd_pkg::*;

  localparam int LOOP_LEN = (CORDIC_STAGES > LOG_STEPS) ? CORDIC_STAGES : LOG_STEPS;
  localparam int CNT_W    = $clog2(LOOP_LEN);
  localparam int CW       = 35;  // CORDIC x/y width, sample << 16 plus growth
  localparam int ZW       = 26;  // angle accumulator, 1/65536 degree

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ_I, ST_SQ_Q, ST_NORM, ST_LOOP, ST_AMP, ST_DONE
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;

  // sample and log path
  logic [15:0] mag_i, mag_q;
  logic        start;
  logic [31:0] power;
  logic        zero;
  logic [4:0]  l_int;
  logic [15:0] frac;
  logic [30:0] xlog;
  logic [15:0] amp_raw;

  // CORDIC path
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic signed [15:0]   phase, prev_phase;

  logic [OFFSET_W-1:0] offset;

  logic accept;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Shared multiplier: squares, mantissa squaring, dB scaling.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    unique case (state)
      ST_SQ_I: begin
        mul_a = {16'd0, mag_i};
        mul_b = {16'd0, mag_i};
      end
      ST_SQ_Q: begin
        mul_a = {16'd0, mag_q};
        mul_b = {16'd0, mag_q};
      end
      ST_LOOP: begin
        mul_a = {1'b0, xlog};
        mul_b = {1'b0, xlog};
      end
      ST_AMP: begin
        mul_a = {11'd0, l_int, frac};
        mul_b = LOG_K;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Leading one of the power and the Q30 mantissa.
  logic [4:0]  msb;
  logic [30:0] xnorm;
  always_comb begin
    msb = '0;
    for (int b = 0; b < 32; b++) begin
      if (power[b]) msb = 5'(b);
    end
  end
  assign xnorm = 31'(({30'd0, power} << 30) >> msb);

  // Absolute values of the incoming sample.
  logic signed [16:0] i_ext, q_ext;
  logic [15:0]        i_abs, q_abs;
  assign i_ext = 17'(in_data.in_phase);
  assign q_ext = 17'(in_data.quadrature);
  assign i_abs = i_ext[16] ? 16'(-i_ext) : i_ext[15:0];
  assign q_abs = q_ext[16] ? 16'(-q_ext) : q_ext[15:0];

  // CORDIC start point: rotate the left half plane by 180 degrees.
  logic signed [CW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;
  always_comb begin
    x0 = CW'(in_data.in_phase) <<< 16;
    y0 = CW'(in_data.quadrature) <<< 16;
    z0 = '0;
    if (x0 < 0) begin
      z0 = (y0 >= 0) ? ZW'(180 * 65536) : -ZW'(180 * 65536);
      x0 = -x0;
      y0 = -y0;
    end
  end

  // One CORDIC micro-rotation.
  logic signed [CW-1:0] xs, ys, cx_next, cy_next;
  logic signed [ZW-1:0] cz_next, atan_k;
  assign xs     = cx >>> cnt;
  assign ys     = cy >>> cnt;
  assign atan_k = ZW'(atan_entry(5'(cnt)));
  always_comb begin
    if (cy >= 0) begin
      cx_next = cx + ys;
      cy_next = cy - xs;
      cz_next = cz + atan_k;
    end else begin
      cx_next = cx - ys;
      cy_next = cy + xs;
      cz_next = cz - atan_k;
    end
  end

  // One log2 fraction bit.
  logic [31:0] sq;
  assign sq = prod[61:30];

  // Angle to 1/128 degree, round half up, clamp to a half turn.
  logic signed [ZW-1:0] z_rnd, z_sh;
  logic signed [15:0]   phase_next;
  assign z_rnd = cz + ZW'(256);
  assign z_sh  = z_rnd >>> 9;
  always_comb begin
    priority if (zero) begin
      phase_next = '0;
    end else if (z_sh > ZW'(HALF_TURN)) begin
      phase_next = 16'(HALF_TURN);
    end else if (z_sh < -ZW'(HALF_TURN)) begin
      phase_next = -16'(HALF_TURN);
    end else begin
      phase_next = 16'(z_sh);
    end
  end

  // Result: offset, saturate, wrap the step.
  logic [63:0]        amp_rnd;
  logic signed [16:0] amp_diff, step_diff;
  out_t               result;
  assign amp_rnd   = prod + 64'h8000_0000;
  assign amp_diff  = $signed({1'b0, amp_raw}) - $signed({2'b0, offset});
  assign step_diff = 17'(phase) - 17'(prev_phase);
  always_comb begin
    priority if (zero) begin
      result.amplitude_db = 16'sh8000;
    end else if (amp_diff > 17'sd32767) begin
      result.amplitude_db = 16'sh7fff;
    end else if (amp_diff < -17'sd32768) begin
      result.amplitude_db = 16'sh8000;
    end else begin
      result.amplitude_db = 16'(amp_diff);
    end
    priority if (start) begin
      result.phase_step = '0;
    end else if (step_diff > 17'(HALF_TURN)) begin
      result.phase_step = 16'(step_diff - 17'(FULL_TURN));
    end else if (step_diff < -17'(HALF_TURN)) begin
      result.phase_step = 16'(step_diff + 17'(FULL_TURN));
    end else begin
      result.phase_step = 16'(step_diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      out_valid  <= 1'b0;
      prev_phase <= '0;
      offset     <= OFFSET_RESET;
    end else begin
      if (cfg_write_enable) offset <= cfg_write_data;
      // Drop the result once taken, unless a new one loads this cycle.
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            mag_i <= i_abs;
            mag_q <= q_abs;
            start <= in_data.start_of_record;
            cx    <= x0;
            cy    <= y0;
            cz    <= z0;
            state <= ST_SQ_I;
          end
        end
        ST_SQ_I: begin
          power <= prod[31:0];
          state <= ST_SQ_Q;
        end
        ST_SQ_Q: begin
          power <= power + prod[31:0];
          state <= ST_NORM;
        end
        ST_NORM: begin
          zero  <= (power == '0);
          l_int <= msb;
          xlog  <= xnorm;
          frac  <= '0;
          cnt   <= '0;
          state <= ST_LOOP;
        end
        ST_LOOP: begin
          if (int'(cnt) < LOG_STEPS) begin
            frac <= {frac[14:0], sq[31]};
            xlog <= sq[31] ? sq[31:1] : sq[30:0];
          end
          if (int'(cnt) < CORDIC_STAGES) begin
            cx <= cx_next;
            cy <= cy_next;
            cz <= cz_next;
          end
          if (cnt == CNT_W'(LOOP_LEN - 1)) begin
            state <= ST_AMP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_AMP: begin
          amp_raw <= amp_rnd[47:32];
          phase   <= phase_next;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || !out_stall) begin
            out_data   <= result;
            out_valid  <= 1'b1;
            prev_phase <= phase;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `IQAPD_CHECK(a_accept_starts, accept |=> state == ST_SQ_I, "accept did not start sequencer")
  `IQAPD_CHECK(a_result_from_done, $rose(out_valid) |-> $past(state == ST_DONE), "result without done")
  `IQAPD_CHECK(a_step_range, out_valid |-> (out_data.phase_step <= 16'sd23040 && out_data.phase_step >= -16'sd23040), "phase step out of range")
  `IQAPD_CHECK(a_loop_bound, state == ST_LOOP |-> int'(cnt) < LOOP_LEN, "loop counter overrun")

endmodule
